FILE: design/isqrt_pkg.sv
// Shared constants and controller/datapath interface types for the integer square root.
// No dependencies.
package isqrt_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int STEPS      = (DATA_WIDTH + 1) / 2;
    localparam int EXT_W      = 2 * STEPS;
    localparam int STEP_W     = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } isqrt_cmd_t;

    typedef struct packed {
        logic bypass;
    } isqrt_sts_t;

endpackage

FILE: design/integer_square_root_top.sv
// Top level of the integer square root: controller plus datapath.
// Depends on isqrt_pkg, isqrt_ctrl, isqrt_dp.
//
//  channel | ports                        | width | direction
//  request | s_valid s_ready s_operand    | 32 s  | in
//  result  | m_valid m_ready m_root       | 32 s  | out
//
// Operands of 2 or more are loaded at the accepting edge, then run 16 bit-pair steps
// of the shared compare/subtract unit, then one result write.
// Operands of 1 or less (negatives included) pass through with no steps.
// One request in flight; the next is taken while a result waits in the output register.
// A held result stalls the write.
// aresetn is synchronous, active low, and clears only control state.
module integer_square_root_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [isqrt_pkg::DATA_WIDTH-1:0] s_operand,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [isqrt_pkg::DATA_WIDTH-1:0] m_root
);

    isqrt_pkg::isqrt_cmd_t cmd;
    isqrt_pkg::isqrt_sts_t sts;

    isqrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    isqrt_dp u_dp (
        .aclk      (aclk),
        .cmd       (cmd),
        .sts       (sts),
        .s_operand (s_operand),
        .m_root    (m_root)
    );

endmodule

FILE: design/isqrt_dp.sv
// Datapath: remainder, root accumulator and bit-pair registers, plus the result register.
// Depends on isqrt_pkg.
module isqrt_dp (
    input  logic                                  aclk,
    input  isqrt_pkg::isqrt_cmd_t                 cmd,
    output isqrt_pkg::isqrt_sts_t                 sts,
    input  logic signed [isqrt_pkg::DATA_WIDTH-1:0] s_operand,
    output logic signed [isqrt_pkg::DATA_WIDTH-1:0] m_root
);

    logic [isqrt_pkg::EXT_W-1:0]   rem_reg, rem_next;
    logic [isqrt_pkg::EXT_W-1:0]   acc_reg, acc_next;
    logic [isqrt_pkg::EXT_W-1:0]   pair_reg, pair_next;
    logic [isqrt_pkg::DATA_WIDTH-1:0] root_reg, root_next;
    logic [isqrt_pkg::EXT_W:0]     trial;
    logic [isqrt_pkg::EXT_W-1:0]   operand_ext;

    assign operand_ext = isqrt_pkg::EXT_W'(unsigned'(s_operand));
    assign sts.bypass  = s_operand[isqrt_pkg::DATA_WIDTH-1]
                         || (s_operand[isqrt_pkg::DATA_WIDTH-1:1] == '0);
    assign trial       = {1'b0, acc_reg} + {1'b0, pair_reg};

    always_comb begin
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        pair_next = pair_reg;
        root_next = root_reg;
        if (cmd.load) begin
            rem_next  = operand_ext;
            pair_next = isqrt_pkg::EXT_W'(1) << (isqrt_pkg::EXT_W - 2);
            acc_next  = sts.bypass ? operand_ext : '0;
        end else if (cmd.step) begin
            pair_next = pair_reg >> 2;
            if ({1'b0, rem_reg} >= trial) begin
                rem_next = rem_reg - trial[isqrt_pkg::EXT_W-1:0];
                acc_next = (acc_reg >> 1) + pair_reg;
            end else begin
                acc_next = acc_reg >> 1;
            end
        end
        if (cmd.out_load) begin
            root_next = acc_reg[isqrt_pkg::DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        pair_reg <= pair_next;
        root_reg <= root_next;
    end

    assign m_root = signed'(root_reg);

endmodule

FILE: design/isqrt_ctrl.sv
// Controller: request handshakes, step sequencing and output valid.
// Depends on isqrt_pkg.
module isqrt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  isqrt_pkg::isqrt_sts_t sts,
    output isqrt_pkg::isqrt_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [isqrt_pkg::STEP_W-1:0]  count_reg, count_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    count_next = '0;
                    state_next = sts.bypass ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                if (count_reg == isqrt_pkg::STEP_W'(isqrt_pkg::STEPS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result register only overwritten once free
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result register overwritten while held");

    // one request in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while busy");

    // every iteration run starts from step zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && state_next == ST_RUN) |=> (count_reg == '0))
        else $error("step counter not cleared at start");

    // load and step never issued together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && cmd.step))
        else $error("conflicting datapath commands");

endmodule
